// File: rtl/mbdlp_pkg.sv
`default_nettype none

package mbdlp_pkg;

    localparam int BUTTON_COUNT = 4;
    localparam int TIME_WIDTH   = 32;

    localparam int NOW_W   = 32;
    localparam int LEVEL_W = 4;
    localparam int MS_W    = 16;
    localparam int MASK_W  = 4;
    localparam int CODE_W  = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE_MS      = 2'd0,
        CFG_LONG_PRESS_MS    = 2'd1,
        CFG_LONG_ENABLE_MASK = 2'd2
    } t_cfg_idx;

    localparam logic [MS_W-1:0]   DEBOUNCE_RST    = 16'd50;
    localparam logic [MS_W-1:0]   LONG_PRESS_RST  = 16'd1000;
    localparam logic [MASK_W-1:0] LONG_ENABLE_RST = 4'd14;

    localparam logic [CODE_W-1:0] EVT_NONE = '0;

    // per-button debounce and press tracking state
    typedef struct packed {
        logic                  prev_level;
        logic                  stable_level;
        logic [TIME_WIDTH-1:0] change_time;
        logic [TIME_WIDTH-1:0] press_start;
        logic                  long_done;
    } t_btn_state;

    // events raised by one button lane in one poll
    typedef struct packed {
        logic short_evt;
        logic long_evt;
    } t_btn_evt;

endpackage

`default_nettype wire

// File: rtl/mbdlp_lane.sv
`default_nettype none

module mbdlp_lane (
    input  wire logic [mbdlp_pkg::TIME_WIDTH-1:0] i_now,
    input  wire logic                             i_raw,
    input  wire logic                             i_long_en,
    input  wire logic [mbdlp_pkg::MS_W-1:0]       i_debounce_ms,
    input  wire logic [mbdlp_pkg::MS_W-1:0]       i_long_press_ms,
    input  wire mbdlp_pkg::t_btn_state            i_state,
    output mbdlp_pkg::t_btn_state                 o_state,
    output mbdlp_pkg::t_btn_evt                   o_evt
);

    localparam int TW = mbdlp_pkg::TIME_WIDTH;

    logic [TW-1:0] change_time;
    logic [TW-1:0] press_start;
    logic [TW-1:0] steady_for;
    logic [TW-1:0] held_for;
    logic          accept;
    logic          stable;
    logic          long_done;
    logic          long_hit;

    always_comb begin
        // restart the debounce timer on any raw change
        change_time = (i_raw != i_state.prev_level) ? i_now : i_state.change_time;
        steady_for  = i_now - change_time;
        accept      = (steady_for > TW'(i_debounce_ms)) && (i_raw != i_state.stable_level);

        stable      = accept ? i_raw : i_state.stable_level;
        press_start = (accept && !i_raw) ? i_now : i_state.press_start;
        long_done   = (accept && !i_raw) ? 1'b0 : i_state.long_done;

        held_for = i_now - press_start;
        long_hit = !stable && i_long_en && !long_done && (held_for > TW'(i_long_press_ms));

        o_evt.short_evt = accept && i_raw && !i_state.long_done;
        o_evt.long_evt  = long_hit;

        o_state.prev_level   = i_raw;
        o_state.stable_level = stable;
        o_state.change_time  = change_time;
        o_state.press_start  = press_start;
        o_state.long_done    = long_done | long_hit;
    end

endmodule

`default_nettype wire

// File: rtl/multi_button_debounce_long_press.sv
`default_nettype none

// Channel   Direction  Handshake                 Word
// in        input      i_in_valid / o_in_ready   i_now_ms[31:0], i_button_levels[3:0]
// out       output     o_out_valid / i_out_ready o_event_code[3:0]
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_index[1:0], i_cfg_data[15:0]
//
// One poll word a cycle while the result is not stalled; each accepted word passes
// through the input register, then through the button lanes into the result
// register. Reset (synchronous, active low) restores all buttons to released and
// the configuration to its defaults. A stalled result holds the input register,
// so the lanes update their state only when a word moves into the result register.

module multi_button_debounce_long_press (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,

    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [mbdlp_pkg::NOW_W-1:0]        i_now_ms,
    input  wire logic [mbdlp_pkg::LEVEL_W-1:0]      i_button_levels,

    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [mbdlp_pkg::CODE_W-1:0]            o_event_code,

    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [mbdlp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [mbdlp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int BC = mbdlp_pkg::BUTTON_COUNT;
    localparam int TW = mbdlp_pkg::TIME_WIDTH;

    // configuration registers
    logic [mbdlp_pkg::MS_W-1:0]   r_debounce_ms;
    logic [mbdlp_pkg::MS_W-1:0]   r_long_press_ms;
    logic [mbdlp_pkg::MASK_W-1:0] r_long_en_mask;

    // input register
    logic                              r_in_valid;
    logic [mbdlp_pkg::NOW_W-1:0]       r_now_ms;
    logic [mbdlp_pkg::LEVEL_W-1:0]     r_levels;

    // result register
    logic                              r_out_valid;
    logic [mbdlp_pkg::CODE_W-1:0]      r_event_code;

    // per-button state
    mbdlp_pkg::t_btn_state r_btn [BC];
    mbdlp_pkg::t_btn_state n_btn [BC];
    mbdlp_pkg::t_btn_evt   lane_evt [BC];

    logic [TW-1:0]                now_t;
    logic [mbdlp_pkg::CODE_W-1:0] n_event_code;
    logic                         advance;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_event_code = r_event_code;

    // reduce or widen the timestamp to the internal time width
    assign now_t = TW'(r_now_ms);

    // one lane per button, all in parallel
    for (genvar g = 0; g < BC; g++) begin : g_lane
        logic raw;
        logic long_en;

        // buttons beyond the level field read as released, beyond the mask as disabled
        if (g < mbdlp_pkg::LEVEL_W) begin : g_raw
            assign raw = r_levels[g];
        end else begin : g_raw_pad
            assign raw = 1'b1;
        end
        if (g < mbdlp_pkg::MASK_W) begin : g_en
            assign long_en = r_long_en_mask[g];
        end else begin : g_en_pad
            assign long_en = 1'b0;
        end

        mbdlp_lane u_lane (
            .i_now           (now_t),
            .i_raw           (raw),
            .i_long_en       (long_en),
            .i_debounce_ms   (r_debounce_ms),
            .i_long_press_ms (r_long_press_ms),
            .i_state         (r_btn[g]),
            .o_state         (n_btn[g]),
            .o_evt           (lane_evt[g])
        );
    end

    // priority encode: the lowest-indexed button wins, so scan from the top down
    always_comb begin
        n_event_code = mbdlp_pkg::EVT_NONE;
        for (int i = BC - 1; i >= 0; i--) begin
            if (lane_evt[i].short_evt) begin
                n_event_code = mbdlp_pkg::CODE_W'(2 * i + 1);
            end else if (lane_evt[i].long_evt) begin
                n_event_code = mbdlp_pkg::CODE_W'(2 * i + 2);
            end
        end
    end

    // configuration writes; an index past the register list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms   <= mbdlp_pkg::DEBOUNCE_RST;
            r_long_press_ms <= mbdlp_pkg::LONG_PRESS_RST;
            r_long_en_mask  <= mbdlp_pkg::LONG_ENABLE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mbdlp_pkg::CFG_DEBOUNCE_MS: begin
                    r_debounce_ms <= i_cfg_data[mbdlp_pkg::MS_W-1:0];
                end
                mbdlp_pkg::CFG_LONG_PRESS_MS: begin
                    r_long_press_ms <= i_cfg_data[mbdlp_pkg::MS_W-1:0];
                end
                mbdlp_pkg::CFG_LONG_ENABLE_MASK: begin
                    r_long_en_mask <= i_cfg_data[mbdlp_pkg::MASK_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // input register: take a new word whenever the slot is free or draining
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_now_ms <= i_now_ms;
            r_levels <= i_button_levels;
        end
    end

    // result register and button state advance together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_event_code <= n_event_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BC; i++) begin
                r_btn[i].prev_level   <= 1'b1;
                r_btn[i].stable_level <= 1'b1;
                r_btn[i].change_time  <= '0;
                r_btn[i].press_start  <= '0;
                r_btn[i].long_done    <= 1'b0;
            end
        end else if (advance) begin
            for (int i = 0; i < BC; i++) begin
                r_btn[i] <= n_btn[i];
            end
        end
    end

endmodule

`default_nettype wire
